// ===== rtl/tcp_single_connection_responder_defines.svh =====
// Assertion helpers used by the responder front (tcpr_front).
// Each expects clk and rst_n in scope.
`ifndef TCP_SINGLE_CONNECTION_RESPONDER_DEFINES_SVH
`define TCP_SINGLE_CONNECTION_RESPONDER_DEFINES_SVH

// Same-cycle implication.
`define TCPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcpr_pkg.sv =====
package tcpr_pkg;

  // TCP flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;

  localparam int unsigned BIT_FIN = 0;
  localparam int unsigned BIT_SYN = 1;
  localparam int unsigned BIT_RST = 2;
  localparam int unsigned BIT_ACK = 4;

  localparam logic [10:0] MAX_PAYLOAD = 11'd1460;

  // configuration port
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_LISTEN_PORT     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_INITIAL_SEQ     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RESPONSE_LENGTH = 2'd2;

  localparam logic [15:0] RST_LISTEN_PORT     = 16'd80;
  localparam logic [31:0] RST_INITIAL_SEQ     = 32'd1000;
  localparam logic [10:0] RST_RESPONSE_LENGTH = 11'd0;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 200;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    CS_LISTEN   = 4'b0001,
    CS_SYN_RCVD = 4'b0010,
    CS_ESTAB    = 4'b0100,
    CS_FIN_WAIT = 4'b1000
  } conn_state_t;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_EVAL = 4'b0010,
    SQ_FIN  = 4'b0100,
    SQ_ACK  = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [15:0] total_len;
    logic [3:0]  ip_words;
    logic [3:0]  tcp_words;
    logic [31:0] ip;
    logic [47:0] mac;
  } seg_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [10:0] plen;
    logic        last;
  } reply_t;

  typedef struct packed {
    logic   valid;
    reply_t data;
  } push_t;

endpackage

// ===== rtl/tcpr_front.sv =====
`include "tcp_single_connection_responder_defines.svh"

module tcpr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          seg_valid_i,
  output logic                          seg_ready_o,
  input  tcpr_pkg::seg_t                seg_i,
  input  logic                          cfg_wr_en_i,
  input  logic [tcpr_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [tcpr_pkg::CFG_DW-1:0]   cfg_wdata_i,
  output tcpr_pkg::push_t               push_o,
  input  logic                          q_full_i
);

  // configuration
  logic [15:0] listen_port_r;
  logic [31:0] initial_seq_r;
  logic [10:0] resp_len_r;

  // connection
  tcpr_pkg::conn_state_t cs_r, cs_nxt;
  logic [47:0] peer_mac_r, peer_mac_nxt;
  logic [31:0] peer_ip_r, peer_ip_nxt;
  logic [15:0] peer_port_r, peer_port_nxt;
  logic [31:0] send_r, send_nxt;
  logic [31:0] recv_r, recv_nxt;

  // held segment
  tcpr_pkg::seq_state_t sq_r, sq_nxt, sq_step;
  logic        it_match_r;
  logic [7:0]  it_flags_r;
  logic [15:0] it_sport_r;
  logic [31:0] it_seq_r;
  logic [31:0] it_ip_r;
  logic [47:0] it_mac_r;
  logic [15:0] it_dlen_r;
  logic        it_dpos_r;

  logic [17:0] dlen_full;
  logic        accept;
  logic        active, push_req, step_done, step_go;
  logic [10:0] plen;
  tcpr_pkg::conn_state_t eff_cs;
  tcpr_pkg::reply_t ent;
  logic        in_close, syn_push, ack_step;

  assign dlen_full = {2'b00, seg_i.total_len}
                   - {12'd0, seg_i.ip_words, 2'b00}
                   - {12'd0, seg_i.tcp_words, 2'b00};

  assign plen = (resp_len_r > tcpr_pkg::MAX_PAYLOAD) ? tcpr_pkg::MAX_PAYLOAD : resp_len_r;

  assign eff_cs = (cs_r == tcpr_pkg::CS_SYN_RCVD && it_flags_r[tcpr_pkg::BIT_ACK])
                ? tcpr_pkg::CS_ESTAB : cs_r;

  always_comb begin
    cs_nxt        = cs_r;
    peer_mac_nxt  = peer_mac_r;
    peer_ip_nxt   = peer_ip_r;
    peer_port_nxt = peer_port_r;
    send_nxt      = send_r;
    recv_nxt      = recv_r;
    sq_step       = tcpr_pkg::SQ_IDLE;
    push_req      = 1'b0;
    step_done     = 1'b1;
    active        = 1'b1;
    ent.mac       = peer_mac_r;
    ent.ip        = peer_ip_r;
    ent.dport     = peer_port_r;
    ent.sport     = listen_port_r;
    ent.seq       = send_r;
    ent.ack       = recv_r;
    ent.flags     = '0;
    ent.plen      = '0;
    ent.last      = 1'b1;
    unique case (sq_r)
      tcpr_pkg::SQ_IDLE: begin
        active = 1'b0;
      end
      tcpr_pkg::SQ_EVAL: begin
        priority if (!it_match_r) begin
          // not our port: drop
        end else if (it_flags_r[tcpr_pkg::BIT_RST]) begin
          cs_nxt = tcpr_pkg::CS_LISTEN;
        end else if (it_flags_r[tcpr_pkg::BIT_SYN]) begin
          peer_mac_nxt  = it_mac_r;
          peer_ip_nxt   = it_ip_r;
          peer_port_nxt = it_sport_r;
          send_nxt      = initial_seq_r + 32'd1;
          recv_nxt      = it_seq_r + 32'd1;
          cs_nxt        = tcpr_pkg::CS_SYN_RCVD;
          push_req      = 1'b1;
          ent.mac       = it_mac_r;
          ent.ip        = it_ip_r;
          ent.dport     = it_sport_r;
          ent.seq       = initial_seq_r;
          ent.ack       = recv_nxt;
          ent.flags     = tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK;
        end else if (eff_cs == tcpr_pkg::CS_ESTAB && it_dpos_r) begin
          recv_nxt  = recv_r + {16'd0, it_dlen_r};
          send_nxt  = send_r + {21'd0, plen};
          cs_nxt    = tcpr_pkg::CS_FIN_WAIT;
          push_req  = 1'b1;
          ent.ack   = recv_nxt;
          ent.flags = tcpr_pkg::FLAG_ACK | tcpr_pkg::FLAG_PSH;
          ent.plen  = plen;
          ent.last  = 1'b0;
          step_done = 1'b0;
          sq_step   = tcpr_pkg::SQ_FIN;
        end else if (eff_cs == tcpr_pkg::CS_FIN_WAIT &&
                     (it_flags_r[tcpr_pkg::BIT_FIN] || it_flags_r[tcpr_pkg::BIT_ACK])) begin
          cs_nxt = tcpr_pkg::CS_LISTEN;
          if (it_flags_r[tcpr_pkg::BIT_FIN]) begin
            recv_nxt  = recv_r + 32'd1;
            push_req  = 1'b1;
            ent.ack   = recv_nxt;
            ent.flags = tcpr_pkg::FLAG_ACK;
          end
        end else begin
          cs_nxt = eff_cs;
        end
      end
      tcpr_pkg::SQ_FIN: begin
        send_nxt  = send_r + 32'd1;
        push_req  = 1'b1;
        ent.flags = tcpr_pkg::FLAG_ACK | tcpr_pkg::FLAG_FIN;
        ent.last  = !it_flags_r[tcpr_pkg::BIT_FIN];
        if (it_flags_r[tcpr_pkg::BIT_FIN]) begin
          step_done = 1'b0;
          sq_step   = tcpr_pkg::SQ_ACK;
        end else if (it_flags_r[tcpr_pkg::BIT_ACK]) begin
          cs_nxt = tcpr_pkg::CS_LISTEN;
        end
      end
      tcpr_pkg::SQ_ACK: begin
        recv_nxt  = recv_r + 32'd1;
        cs_nxt    = tcpr_pkg::CS_LISTEN;
        push_req  = 1'b1;
        ent.ack   = recv_nxt;
        ent.flags = tcpr_pkg::FLAG_ACK;
      end
      default: begin
        active = 1'b0;
      end
    endcase
  end

  // a step commits only when its reply has room
  assign step_go     = active && (!push_req || !q_full_i);
  assign seg_ready_o = (sq_r == tcpr_pkg::SQ_IDLE) || (step_go && step_done);
  assign accept      = seg_valid_i && seg_ready_o;

  assign push_o.valid = step_go && push_req;
  assign push_o.data  = ent;

  always_comb begin
    sq_nxt = sq_r;
    if (step_go) begin
      sq_nxt = step_done ? tcpr_pkg::SQ_IDLE : sq_step;
    end
    if (accept) begin
      sq_nxt = tcpr_pkg::SQ_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_port_r <= tcpr_pkg::RST_LISTEN_PORT;
      initial_seq_r <= tcpr_pkg::RST_INITIAL_SEQ;
      resp_len_r    <= tcpr_pkg::RST_RESPONSE_LENGTH;
    end else if (cfg_wr_en_i) begin
      if (cfg_addr_i == tcpr_pkg::REG_LISTEN_PORT) listen_port_r <= cfg_wdata_i[15:0];
      if (cfg_addr_i == tcpr_pkg::REG_INITIAL_SEQ) initial_seq_r <= cfg_wdata_i;
      if (cfg_addr_i == tcpr_pkg::REG_RESPONSE_LENGTH) resp_len_r <= cfg_wdata_i[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= tcpr_pkg::SQ_IDLE;
      cs_r        <= tcpr_pkg::CS_LISTEN;
      peer_mac_r  <= '0;
      peer_ip_r   <= '0;
      peer_port_r <= '0;
      send_r      <= '0;
      recv_r      <= '0;
    end else begin
      sq_r <= sq_nxt;
      if (step_go) begin
        cs_r        <= cs_nxt;
        peer_mac_r  <= peer_mac_nxt;
        peer_ip_r   <= peer_ip_nxt;
        peer_port_r <= peer_port_nxt;
        send_r      <= send_nxt;
        recv_r      <= recv_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_match_r <= (seg_i.dport == listen_port_r);
      it_flags_r <= seg_i.flags;
      it_sport_r <= seg_i.sport;
      it_seq_r   <= seg_i.seq;
      it_ip_r    <= seg_i.ip;
      it_mac_r   <= seg_i.mac;
      it_dlen_r  <= dlen_full[15:0];
      it_dpos_r  <= !dlen_full[17] && (dlen_full[16:0] != 17'd0);
    end
  end

  assign in_close = (sq_r == tcpr_pkg::SQ_FIN) || (sq_r == tcpr_pkg::SQ_ACK);
  assign syn_push = push_o.valid && (ent.flags == (tcpr_pkg::FLAG_SYN | tcpr_pkg::FLAG_ACK));
  assign ack_step = step_go && (sq_r == tcpr_pkg::SQ_ACK);

  `TCPR_ASSERT_IMP(a_push_room, push_o.valid, !q_full_i, "reply pushed into a full queue")
  `TCPR_ASSERT_IMP(a_close_phase, in_close, cs_r == tcpr_pkg::CS_FIN_WAIT, "close off fin-wait")
  `TCPR_ASSERT_NXT(a_syn_opens, syn_push, cs_r == tcpr_pkg::CS_SYN_RCVD, "SYN did not open")
  `TCPR_ASSERT_NXT(a_ack_closes, ack_step, cs_r == tcpr_pkg::CS_LISTEN, "final ACK kept open")

endmodule

// ===== rtl/tcpr_queue.sv =====
module tcpr_queue #(
  parameter int unsigned DEPTH = tcpr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcpr_pkg::push_t   push_i,
  output logic              full_o,
  output logic              valid_o,
  output tcpr_pkg::reply_t  data_o,
  input  logic              pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tcpr_pkg::reply_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full_o  = (count_r == CW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign data_o  = mem[rd_ptr_r];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + CW'(1);
    if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_i.data;
  end

endmodule

// ===== rtl/tcpr_back.sv =====
module tcpr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid_i,
  input  tcpr_pkg::reply_t  q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcpr_pkg::reply_t  out_data_o
);

  logic             out_valid_r;
  tcpr_pkg::reply_t out_data_r;

  // refill the output register whenever it is empty or being drained
  assign q_pop_o     = q_valid_i && (!out_valid_r || out_ready_i);
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready_i) begin
      out_valid_r <= q_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop_o) out_data_r <= q_data_i;
  end

endmodule

// ===== rtl/tcp_single_connection_responder.sv =====
// Single-connection TCP responder (passive open).
// Input channel in_*: one word per received segment header, already parsed.
// Output channel out_*: one word per reply segment header; out_tlast marks the
// final reply that a segment causes (a segment causes zero to three replies).
// Config port cfg_*: listen_port (0), initial_seq (1), response_length (2);
// write only while no segment is in flight.
// Sequencing: each segment is evaluated in SQ_EVAL; a data segment then steps
// through SQ_FIN to send its FIN, and also through SQ_ACK if it carries FIN.
// RST, SYN, ignored and FIN-only segments take the SQ_EVAL step alone. The
// sequencer updates the connection registers at each step it commits, and a
// step holds while the reply queue is full.
// Path: the first reply passes the sequencer, the reply queue and the output
// register before it is valid on out_tvalid.
// A reply queue of QUEUE_DEPTH words sits between the sequencer and the output
// register; when the receiver stalls the queue fills, then the sequencer holds
// and in_tready drops. Nothing is lost or reordered.
// Reset (rst_n low, synchronous): config back to 80 / 1000 / 0, connection to
// listen with cleared peer and sequence registers, queue emptied.
module tcp_single_connection_responder #(
  parameter int unsigned QUEUE_DEPTH = tcpr_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // seg_dst_port, seg_src_port, seg_seq, seg_flags, ip_total_length,
  // ip_header_words, tcp_header_words, sender_ip, sender_mac
  input  logic [tcpr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // reply_mac, reply_ip, reply_dst_port, reply_src_port, reply_seq,
  // reply_ack, reply_flags, payload_length, zero pad
  output logic [tcpr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_wr_en,
  input  logic [tcpr_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [tcpr_pkg::CFG_DW-1:0]        cfg_wdata
);

  tcpr_pkg::seg_t   seg;
  tcpr_pkg::push_t  push;
  tcpr_pkg::reply_t q_data;
  tcpr_pkg::reply_t out_data;
  logic             q_full, q_valid, q_pop;

  // unpack the input word, lowest field first
  assign seg.dport     = in_tdata[15:0];
  assign seg.sport     = in_tdata[31:16];
  assign seg.seq       = in_tdata[63:32];
  assign seg.flags     = in_tdata[71:64];
  assign seg.total_len = in_tdata[87:72];
  assign seg.ip_words  = in_tdata[91:88];
  assign seg.tcp_words = in_tdata[95:92];
  assign seg.ip        = in_tdata[127:96];
  assign seg.mac       = in_tdata[175:128];

  // front: classify segments, step the connection, emit reply headers
  tcpr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .seg_valid_i (in_tvalid),
    .seg_ready_o (in_tready),
    .seg_i       (seg),
    .cfg_wr_en_i (cfg_wr_en),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata),
    .push_o      (push),
    .q_full_i    (q_full)
  );

  // decouple sequencer from downstream stalls
  tcpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  // back: registered output stage
  tcpr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_data)
  );

  // pack the reply word, lowest field first
  assign out_tdata = {5'd0, out_data.plen, out_data.flags, out_data.ack, out_data.seq,
                      out_data.sport, out_data.dport, out_data.ip, out_data.mac};
  assign out_tlast = out_data.last;

endmodule
